// File: rtl/bfdh_pkg.sv
// ----------------------------------------------------------------------------
// bfdh_pkg
// Shared types and constants for the double-hashing bloom filter.
// ----------------------------------------------------------------------------
package bfdh_pkg;

	localparam int STORE_BITS_LOG2_DEF = 16;

	localparam int KEY_W       = 32;
	localparam int SIZE_W      = 5;
	localparam int PROBE_W     = 4;
	localparam int CFG_W       = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int PROBE_IDX_W = 3;
	localparam int WORD_W      = 64;
	localparam int BIT_SEL_W   = 6;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT = 2'd1;

	localparam logic [SIZE_W-1:0]  SIZE_LOG2_RST   = 5'd16;
	localparam logic [PROBE_W-1:0] PROBE_COUNT_RST = 4'd3;
	localparam logic [PROBE_W-1:0] MAX_PROBES      = 4'd8;

	// splitmix64 finalizer constants
	localparam logic [63:0] MIX_ADD  = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] MIX_MUL1 = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [63:0] MIX_MUL2 = 64'h94d0_49bb_1331_11eb;

	localparam int MIX_SH1 = 30;
	localparam int MIX_SH2 = 27;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL_LL,
		ST_MUL_LH,
		ST_MUL_HL,
		ST_XSH,
		ST_PROBE_RD,
		ST_PROBE_UPD,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_LL,
		MUL_LH,
		MUL_HL
	} mul_op_t;

	typedef struct packed {
		logic    load;
		mul_op_t mul_op;
		logic    round;
		logic    xsh;
	} mix_ctrl_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} store_ctrl_t;

endpackage

// File: rtl/bfdh_mix.sv
// ----------------------------------------------------------------------------
// bfdh_mix
// Second hash from the key hash: splitmix64 finalizer on one shared
// 32x32 multiplier, three partial products per 64-bit multiply.
// ----------------------------------------------------------------------------
module bfdh_mix (
	input  logic                           clk,
	input  bfdh_pkg::mix_ctrl_t            ctrl,
	input  logic [bfdh_pkg::KEY_W-1:0]     key_hash,
	output logic [bfdh_pkg::KEY_W-1:0]     h2
);

	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [63:0] cst;
	logic [63:0] v_load;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;

	assign cst    = ctrl.round ? bfdh_pkg::MIX_MUL2 : bfdh_pkg::MIX_MUL1;
	assign v_load = {32'd0, key_hash} + bfdh_pkg::MIX_ADD;

	// operand select for the shared multiplier
	always_comb begin
		case (ctrl.mul_op)
			bfdh_pkg::MUL_LL: begin
				mul_a = x_q[31:0];
				mul_b = cst[31:0];
			end
			bfdh_pkg::MUL_LH: begin
				mul_a = x_q[31:0];
				mul_b = cst[63:32];
			end
			bfdh_pkg::MUL_HL: begin
				mul_a = x_q[63:32];
				mul_b = cst[31:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = {32'd0, mul_a} * {32'd0, mul_b};

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q <= v_load ^ (v_load >> bfdh_pkg::MIX_SH1);
		end else if (ctrl.xsh) begin
			x_q <= acc_q ^ (acc_q >> bfdh_pkg::MIX_SH2);
		end
		case (ctrl.mul_op)
			bfdh_pkg::MUL_LL: acc_q <= prod;
			bfdh_pkg::MUL_LH,
			bfdh_pkg::MUL_HL: acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			default: acc_q <= acc_q;
		endcase
	end

	// upper half of the final xor-shift 31 only touches bit 32, which is forced odd
	assign h2 = {acc_q[63:33], 1'b1};

endmodule

// File: rtl/bfdh_store.sv
// ----------------------------------------------------------------------------
// bfdh_store
// Filter bit store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bfdh_store #(
	parameter int ADDR_W = bfdh_pkg::STORE_BITS_LOG2_DEF - bfdh_pkg::BIT_SEL_W
) (
	input  logic                          clk,
	input  bfdh_pkg::store_ctrl_t         ctrl,
	input  logic [ADDR_W-1:0]             addr,
	input  logic [bfdh_pkg::WORD_W-1:0]   wdata,
	output logic [bfdh_pkg::WORD_W-1:0]   rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [bfdh_pkg::WORD_W-1:0] mem [DEPTH];
	logic [bfdh_pkg::WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[addr] <= wdata;
		end
		if (ctrl.rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/bloom_filter_double_hash.sv
// ----------------------------------------------------------------------------
// bloom_filter_double_hash
// Bloom filter with double hashing over an internal bit store.
// ----------------------------------------------------------------------------
// Each transaction on the input channel carries a 32-bit key hash h1 and a
// request type (insert or query) and produces exactly one transaction on the
// output channel. The block derives h2 from h1 with the splitmix64 finalizer,
// running both 64-bit multiplies on one shared 32x32 multiplier (three
// partial products each), then walks probe_count probes (h1 + i*h2) masked to
// 2^size_log2 bits; each probe is a read and then an update/check on the
// single-port store. An item holds the block through the mixer (key load
// on acceptance, three partial products, an xor-shift, three more), a read
// and an update/check state per probe (1..8 probes, three at reset) and a
// done state that hands the result to the output register and returns to
// idle. A finished result sits in an output register, so the next item is
// taken even while the result waits; that item then stalls in its done
// state until the result is accepted. After reset the store is swept to
// zero, one 64-bit word per cycle, keeping in_ready low until all of the
// 2^(STORE_BITS_LOG2-6) words are cleared. Configuration writes are taken at
// any time but are meant for idle periods; writing does not clear the store.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash #(
	parameter int STORE_BITS_LOG2 = bfdh_pkg::STORE_BITS_LOG2_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              req_type,
	input  logic [bfdh_pkg::KEY_W-1:0]        key_hash,
	// output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              maybe_present,
	// configuration
	input  logic                              cfg_we,
	input  logic [bfdh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bfdh_pkg::CFG_W-1:0]        cfg_wdata
);

	localparam int ADDR_W = STORE_BITS_LOG2 - bfdh_pkg::BIT_SEL_W;
	localparam int IDX_W  = STORE_BITS_LOG2;

	bfdh_pkg::state_t state_q, state_d;

	// configuration registers
	logic [bfdh_pkg::SIZE_W-1:0]      size_log2_q;
	logic [bfdh_pkg::PROBE_W-1:0]     probe_count_q;

	// per-item working registers
	logic                             round_q;
	logic                             is_query_q;
	logic                             all_set_q;
	logic [bfdh_pkg::PROBE_IDX_W-1:0] probe_idx_q;
	logic [bfdh_pkg::PROBE_IDX_W-1:0] probe_last_q;
	logic [IDX_W-1:0]                 idx_q;
	logic [ADDR_W-1:0]                clr_q;

	// output register
	logic                             out_valid_q;
	logic                             maybe_present_q;

	// datapath
	logic [bfdh_pkg::KEY_W-1:0]       h2;
	logic [bfdh_pkg::SIZE_W-1:0]      size_eff;
	logic [IDX_W-1:0]                 mask;
	logic [IDX_W-1:0]                 idx_masked;
	logic [ADDR_W-1:0]                word_addr;
	logic [bfdh_pkg::BIT_SEL_W-1:0]   bit_sel;
	logic [bfdh_pkg::WORD_W-1:0]      rdata;
	logic [bfdh_pkg::WORD_W-1:0]      wdata;
	logic [ADDR_W-1:0]                store_addr;
	logic [bfdh_pkg::PROBE_IDX_W-1:0] probe_last_d;
	logic                             hit;
	logic                             in_fire;
	logic                             out_load;
	logic                             last_probe;

	bfdh_pkg::mix_ctrl_t              mix_ctrl;
	bfdh_pkg::store_ctrl_t            store_ctrl;

	assign in_fire    = in_valid && in_ready;
	assign last_probe = (probe_idx_q == probe_last_q);

	// effective index mask: size above the store is clamped to the store
	always_comb begin
		size_eff = (size_log2_q > bfdh_pkg::SIZE_W'(STORE_BITS_LOG2))
			? bfdh_pkg::SIZE_W'(STORE_BITS_LOG2) : size_log2_q;
		for (int b = 0; b < IDX_W; b++) begin
			mask[b] = (b < int'(size_eff));
		end
	end

	assign idx_masked = idx_q & mask;
	assign word_addr  = idx_masked[IDX_W-1:bfdh_pkg::BIT_SEL_W];
	assign bit_sel    = idx_masked[bfdh_pkg::BIT_SEL_W-1:0];
	assign hit        = rdata[bit_sel];

	// zero probes act as one, more than eight act as eight
	always_comb begin
		if (probe_count_q == '0) begin
			probe_last_d = '0;
		end else if (probe_count_q > bfdh_pkg::MAX_PROBES) begin
			probe_last_d = bfdh_pkg::PROBE_IDX_W'(bfdh_pkg::MAX_PROBES - 4'd1);
		end else begin
			probe_last_d = bfdh_pkg::PROBE_IDX_W'(probe_count_q - 4'd1);
		end
	end

	// store port: clear sweep after reset, probes otherwise
	assign store_addr = (state_q == bfdh_pkg::ST_CLEAR) ? clr_q : word_addr;
	assign wdata      = (state_q == bfdh_pkg::ST_CLEAR) ? '0
		: (rdata | (bfdh_pkg::WORD_W'(1) << bit_sel));

	// sequencer
	always_comb begin
		state_d           = state_q;
		mix_ctrl.load     = 1'b0;
		mix_ctrl.mul_op   = bfdh_pkg::MUL_NONE;
		mix_ctrl.round    = round_q;
		mix_ctrl.xsh      = 1'b0;
		store_ctrl.rd_en  = 1'b0;
		store_ctrl.wr_en  = 1'b0;
		in_ready          = 1'b0;
		out_load          = 1'b0;
		case (state_q)
			bfdh_pkg::ST_CLEAR: begin
				store_ctrl.wr_en = 1'b1;
				if (clr_q == '1) begin
					state_d = bfdh_pkg::ST_IDLE;
				end
			end
			bfdh_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					mix_ctrl.load = 1'b1;
					state_d       = bfdh_pkg::ST_MUL_LL;
				end
			end
			bfdh_pkg::ST_MUL_LL: begin
				mix_ctrl.mul_op = bfdh_pkg::MUL_LL;
				state_d         = bfdh_pkg::ST_MUL_LH;
			end
			bfdh_pkg::ST_MUL_LH: begin
				mix_ctrl.mul_op = bfdh_pkg::MUL_LH;
				state_d         = bfdh_pkg::ST_MUL_HL;
			end
			bfdh_pkg::ST_MUL_HL: begin
				mix_ctrl.mul_op = bfdh_pkg::MUL_HL;
				state_d         = round_q ? bfdh_pkg::ST_PROBE_RD : bfdh_pkg::ST_XSH;
			end
			bfdh_pkg::ST_XSH: begin
				mix_ctrl.xsh = 1'b1;
				state_d      = bfdh_pkg::ST_MUL_LL;
			end
			bfdh_pkg::ST_PROBE_RD: begin
				store_ctrl.rd_en = 1'b1;
				state_d          = bfdh_pkg::ST_PROBE_UPD;
			end
			bfdh_pkg::ST_PROBE_UPD: begin
				// insert writes the word back with the probed bit set
				store_ctrl.wr_en = !is_query_q;
				state_d = last_probe ? bfdh_pkg::ST_DONE : bfdh_pkg::ST_PROBE_RD;
			end
			bfdh_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = bfdh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bfdh_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfdh_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log2_q   <= bfdh_pkg::SIZE_LOG2_RST;
			probe_count_q <= bfdh_pkg::PROBE_COUNT_RST;
		end else if (cfg_we) begin
			if (cfg_index == bfdh_pkg::REG_SIZE_LOG2) begin
				size_log2_q <= cfg_wdata[bfdh_pkg::SIZE_W-1:0];
			end else if (cfg_index == bfdh_pkg::REG_PROBE_COUNT) begin
				probe_count_q <= cfg_wdata[bfdh_pkg::PROBE_W-1:0];
			end
		end
	end

	// clear sweep counter and mixer round
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			round_q <= 1'b0;
		end else begin
			if (state_q == bfdh_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (in_fire) begin
				round_q <= 1'b0;
			end else if (state_q == bfdh_pkg::ST_XSH) begin
				round_q <= 1'b1;
			end
		end
	end

	// probe walk state
	always_ff @(posedge clk) begin
		if (in_fire) begin
			is_query_q   <= req_type;
			idx_q        <= key_hash[IDX_W-1:0];
			probe_idx_q  <= '0;
			probe_last_q <= probe_last_d;
			all_set_q    <= 1'b1;
		end else if (state_q == bfdh_pkg::ST_PROBE_UPD) begin
			all_set_q   <= all_set_q & hit;
			probe_idx_q <= probe_idx_q + 1'b1;
			idx_q       <= idx_q + h2[IDX_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			maybe_present_q <= is_query_q & all_set_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign maybe_present = maybe_present_q;

	bfdh_mix u_mix (
		.clk      (clk),
		.ctrl     (mix_ctrl),
		.key_hash (key_hash),
		.h2       (h2)
	);

	bfdh_store #(
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.ctrl  (store_ctrl),
		.addr  (store_addr),
		.wdata (wdata),
		.rdata (rdata)
	);

endmodule

// File: rtl/bfdh_checker.sv
// ----------------------------------------------------------------------------
// bfdh_checker
// Port-level checks for the bloom filter, bound to the top level.
// ----------------------------------------------------------------------------
module bfdh_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic maybe_present
);

	// a waiting result holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(maybe_present))
		else $error("result changed while stalled");

	// the block is busy right after taking a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");

	// mixing plus at least one probe keeps the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##10 !in_ready)
		else $error("item finished too early");

	// a new result only appears out of a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without work");

endmodule

bind bloom_filter_double_hash bfdh_checker u_bfdh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.maybe_present (maybe_present)
);
